// ===== src/dew_pkg.sv =====
// shared types, constants and helper functions of the delta escape width encoder
package dew_pkg;

    localparam int unsigned VALUE_BITS  = 63;
    localparam int unsigned DIFF_BITS   = 64;
    localparam int unsigned OFFSET_BITS = 17;
    localparam int unsigned LIMIT_BITS  = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    typedef logic [1:0] width_code_t;

    localparam width_code_t WIDTH_1 = 2'd0;
    localparam width_code_t WIDTH_2 = 2'd1;
    localparam width_code_t WIDTH_4 = 2'd2;
    localparam width_code_t WIDTH_8 = 2'd3;

    localparam logic signed [DIFF_BITS-1:0] FIT1_MAX = 64'sd127;
    localparam logic signed [DIFF_BITS-1:0] FIT2_MAX = 64'sd32767;
    localparam logic signed [DIFF_BITS-1:0] FIT4_MAX = 64'sd2147483647;

    localparam logic [7:0] ESCAPE_TOP = 8'h80;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    typedef struct packed {
        logic [DIFF_BITS-1:0] diff;
        width_code_t          start_wc;
        width_code_t          need_wc;
        logic                 first;
        logic                 last;
    } entry_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DATA,
        PH_ESC,
        PH_PAD,
        PH_LPAD
    } phase_t;

    function automatic logic [DIFF_BITS-1:0] widen(input logic [VALUE_BITS-1:0] v);
        return {{(DIFF_BITS - VALUE_BITS){v[VALUE_BITS-1]}}, v};
    endfunction

    function automatic width_code_t need_code(input logic [DIFF_BITS-1:0] d);
        logic signed [DIFF_BITS-1:0] s;
        s = $signed(d);
        if (s >= -FIT1_MAX && s <= FIT1_MAX)
            return WIDTH_1;
        else if (s >= -FIT2_MAX && s <= FIT2_MAX)
            return WIDTH_2;
        else if (s >= -FIT4_MAX && s <= FIT4_MAX)
            return WIDTH_4;
        else
            return WIDTH_8;
    endfunction

    function automatic logic [2:0] last_index(input width_code_t wc);
        case (wc)
            WIDTH_1: return 3'd0;
            WIDTH_2: return 3'd1;
            WIDTH_4: return 3'd3;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [2:0] double_mask(input width_code_t wc);
        case (wc)
            WIDTH_1: return 3'd1;
            WIDTH_2: return 3'd3;
            default: return 3'd7;
        endcase
    endfunction

endpackage

// ===== src/delta_escape_width_encoder_unit.sv =====
// top level of the delta escape width encoder
// an item's first byte passes a queue slot, item registers and the output register
// throughput: one byte per cycle while out_stall is low; an item makes 1 to 22 bytes
// (about 8 for a run settled at 8-byte width), as set by the byte sequencer
// a 2-entry queue lets the input side take items while bytes are still going out
// reset: asynchronous active low; clears run state, queue, output valid, limit to 65535
module delta_escape_width_encoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dew_pkg::LIMIT_BITS-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dew_pkg::VALUE_BITS-1:0]  sample_value,
    input  logic                            first_of_run,
    input  logic                            last_of_run,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            end_of_item,
    output logic                            end_of_run,
    output logic                            too_long
);
    import dew_pkg::*;

    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;

    dew_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .first_of_run (first_of_run),
        .last_of_run  (last_of_run),
        .q_full       (full),
        .q_push       (push),
        .q_entry      (push_entry)
    );

    dew_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    dew_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .q_empty     (empty),
        .q_head      (head),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .end_of_item (end_of_item),
        .end_of_run  (end_of_run),
        .too_long    (too_long)
    );

endmodule

// ===== src/dew_front.sv =====
// front end: accepts items, forms the difference and classifies its width
module dew_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dew_pkg::VALUE_BITS-1:0]  sample_value,
    input  logic                            first_of_run,
    input  logic                            last_of_run,
    input  logic                            q_full,
    output logic                            q_push,
    output dew_pkg::entry_t                 q_entry
);
    import dew_pkg::*;

    logic [VALUE_BITS-1:0] prev_reg;
    logic [VALUE_BITS-1:0] prev_next;
    width_code_t           wc_reg;
    width_code_t           wc_next;
    logic [VALUE_BITS-1:0] prev_base;
    width_code_t           wc_base;
    logic [DIFF_BITS-1:0]  diff;
    width_code_t           need;

    always_comb
    begin
        in_stall  = q_full;
        q_push    = in_valid && !q_full;
        prev_base = first_of_run ? '0 : prev_reg;
        wc_base   = first_of_run ? WIDTH_1 : wc_reg;
        diff      = widen(sample_value) - widen(prev_base);
        need      = need_code(diff);
        q_entry.diff     = diff;
        q_entry.start_wc = wc_base;
        q_entry.need_wc  = need;
        q_entry.first    = first_of_run;
        q_entry.last     = last_of_run;
        prev_next = prev_reg;
        wc_next   = wc_reg;
        if (q_push)
        begin
            prev_next = sample_value;
            wc_next   = (need > wc_base) ? need : wc_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            wc_reg   <= WIDTH_1;
        end
        else
        begin
            prev_reg <= prev_next;
            wc_reg   <= wc_next;
        end
    end

endmodule

// ===== src/dew_queue.sv =====
// short item queue between the front end and the byte sequencer
module dew_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dew_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output dew_pkg::entry_t head,
    output logic            empty
);
    import dew_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    always_comb
    begin
        full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
        empty   = (count_reg == '0);
        head    = slot_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== src/dew_back.sv =====
// byte sequencer: data, escape and pad bytes with run byte count and limit check
module dew_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dew_pkg::LIMIT_BITS-1:0]  cfg_data,
    input  logic                            q_empty,
    input  dew_pkg::entry_t                 q_head,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            end_of_item,
    output logic                            end_of_run,
    output logic                            too_long
);
    import dew_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   ovf_reg, ovf_next;
    logic [LIMIT_BITS-1:0]  limit_reg;
    logic [DIFF_BITS-1:0]   diff_reg, diff_next;
    width_code_t            wc_reg, wc_next;
    width_code_t            need_reg, need_next;
    logic                   last_reg, last_next;
    logic [2:0]             idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   eoi_reg, eoi_next;
    logic                   eor_reg, eor_next;
    logic                   too_long_reg, too_long_next;

    logic                   advance;
    logic                   emit;
    logic                   final_byte;
    logic                   load;
    logic [7:0]             cur_byte;
    logic [OFFSET_BITS-1:0] off_inc;
    logic                   ovf_inc;
    width_code_t            wc_up;
    logic                   at_end;
    logic                   aligned2w;

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        ovf_next       = ovf_reg;
        diff_next      = diff_reg;
        wc_next        = wc_reg;
        need_next      = need_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        eoi_next       = eoi_reg;
        eor_next       = eor_reg;
        too_long_next  = too_long_reg;
        emit           = 1'b0;
        final_byte     = 1'b0;
        cur_byte       = PAD_BYTE;

        advance   = !out_valid_reg || !out_stall;
        off_inc   = offset_reg + 1'b1;
        ovf_inc   = ovf_reg || (off_inc > {1'b0, limit_reg});
        wc_up     = wc_reg + 1'b1;
        at_end    = (idx_reg == last_index(wc_reg));
        aligned2w = ((off_inc[2:0] & double_mask(wc_reg)) == 3'd0);

        if (advance && phase_reg != PH_IDLE)
        begin
            emit        = 1'b1;
            offset_next = off_inc;
            ovf_next    = ovf_inc;
            case (phase_reg)
                PH_DATA:
                begin
                    cur_byte = diff_reg[8*idx_reg +: 8];
                    if (at_end)
                    begin
                        if (last_reg && off_inc[2:0] != 3'd0)
                            phase_next = PH_LPAD;
                        else
                            final_byte = 1'b1;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                PH_ESC:
                begin
                    cur_byte = at_end ? ESCAPE_TOP : PAD_BYTE;
                    if (at_end)
                    begin
                        idx_next = '0;
                        if (aligned2w)
                        begin
                            wc_next    = wc_up;
                            phase_next = (wc_up >= need_reg) ? PH_DATA : PH_ESC;
                        end
                        else
                            phase_next = PH_PAD;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                PH_PAD:
                begin
                    if (aligned2w)
                    begin
                        wc_next    = wc_up;
                        phase_next = (wc_up >= need_reg) ? PH_DATA : PH_ESC;
                    end
                end
                PH_LPAD:
                begin
                    if (off_inc[2:0] == 3'd0)
                        final_byte = 1'b1;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (final_byte)
                phase_next = PH_IDLE;
        end

        load  = !q_empty && (phase_reg == PH_IDLE || final_byte);
        q_pop = load;
        if (load)
        begin
            diff_next  = q_head.diff;
            wc_next    = q_head.start_wc;
            need_next  = q_head.need_wc;
            last_next  = q_head.last;
            idx_next   = '0;
            phase_next = (q_head.start_wc >= q_head.need_wc) ? PH_DATA : PH_ESC;
            if (q_head.first)
            begin
                offset_next = '0;
                ovf_next    = 1'b0;
            end
        end

        if (advance)
        begin
            out_valid_next = emit;
            out_byte_next  = cur_byte;
            eoi_next       = final_byte;
            eor_next       = final_byte && last_reg;
            too_long_next  = ovf_inc;
        end

        out_valid   = out_valid_reg;
        out_byte    = out_byte_reg;
        end_of_item = eoi_reg;
        end_of_run  = eor_reg;
        too_long    = too_long_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            offset_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        wc_reg       <= wc_next;
        need_reg     <= need_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        eoi_reg      <= eoi_next;
        eor_reg      <= eor_next;
        too_long_reg <= too_long_next;
    end

endmodule

// ===== src/dew_checker.sv =====
// port level checks of the delta escape width encoder and their bind
module dew_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       end_of_item,
    input logic       end_of_run,
    input logic       too_long
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(end_of_item)
            && $stable(end_of_run) && $stable(too_long))
        else $error("stalled output byte changed");

    a_run_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_run |-> end_of_item)
        else $error("end of run without end of item");

    a_quiet_after_reset: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind delta_escape_width_encoder_unit dew_checker u_dew_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .end_of_item (end_of_item),
    .end_of_run  (end_of_run),
    .too_long    (too_long)
);

// ===== tb/delta_escape_width_encoder_unit_tb.sv =====
// testbench of the delta escape width encoder: runs of samples checked byte by byte against a predictor
module delta_escape_width_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dew_pkg::*;

    localparam int CYCLE_LIMIT    = 2_000_000;

    localparam logic [VALUE_BITS-1:0] SAMPLE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] SAMPLE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [7:0] data;
        logic       item_end;
        logic       run_end;
        logic       over_limit;
    } stream_byte_t;

    class byte_stream_scoreboard;
        logic [LIMIT_BITS-1:0]  limit;
        logic [VALUE_BITS-1:0]  prev_value;
        width_code_t            width;
        logic [OFFSET_BITS-1:0] run_offset;
        logic                   overflow;
        stream_byte_t           expected_bytes[$];
        int                     errors;

        function new();
            limit = LIMIT_RESET;
            prev_value = '0;
            width = WIDTH_1;
            run_offset = '0;
            overflow = 1'b0;
            errors = 0;
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] data);
            stream_byte_t b;
            run_offset = run_offset + 1'b1;
            if (run_offset > {1'b0, limit})
                overflow = 1'b1;
            b.data = data;
            b.item_end = 1'b0;
            b.run_end = 1'b0;
            b.over_limit = overflow;
            expected_bytes.push_back(b);
        endfunction

        function void pad_to(int align);
            while ((run_offset & OFFSET_BITS'(align - 1)) != 0)
                push_byte(PAD_BYTE);
        endfunction

        function void push_le(logic [DIFF_BITS-1:0] value, int nbytes);
            for (int i = 0; i < nbytes; i++)
                push_byte(value[8*i +: 8]);
        endfunction

        // encodes one accepted item into the bytes it must produce
        function void encode_sample(logic [VALUE_BITS-1:0] value, logic first, logic last);
            logic signed [DIFF_BITS-1:0] cur_wide;
            logic signed [DIFF_BITS-1:0] prev_wide;
            logic [DIFF_BITS-1:0]        diff;
            logic [DIFF_BITS-1:0]        half;
            int                          w;
            if (first)
            begin
                prev_value = '0;
                width = WIDTH_1;
                run_offset = '0;
                overflow = 1'b0;
            end
            cur_wide = $signed(value);
            prev_wide = $signed(prev_value);
            diff = cur_wide - prev_wide;
            forever
            begin
                w = 1 << width;
                if (w >= 8)
                begin
                    push_le(diff, 8);
                    break;
                end
                half = 64'd1 << (8 * w - 1);
                if (diff + (half - 64'd1) <= (half << 1) - 64'd2)
                begin
                    push_le(diff, w);
                    break;
                end
                // escape marker, then align to the doubled width
                push_le(half, w);
                pad_to(2 * w);
                width = width + 2'd1;
            end
            if (last)
                pad_to(8);
            prev_value = value;
            expected_bytes[expected_bytes.size() - 1].item_end = 1'b1;
            if (last)
                expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
        endfunction

        function void check_byte(logic [7:0] data, logic item_end, logic run_end,
                                 logic over_limit);
            stream_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte expected none actual %0h", data);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte expected %0h actual %0h", want.data, data);
                errors++;
            end
            if (item_end !== want.item_end)
            begin
                $error("end_of_item expected %0b actual %0b", want.item_end, item_end);
                errors++;
            end
            if (run_end !== want.run_end)
            begin
                $error("end_of_run expected %0b actual %0b", want.run_end, run_end);
                errors++;
            end
            if (over_limit !== want.over_limit)
            begin
                $error("too_long expected %0b actual %0b", want.over_limit, over_limit);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [LIMIT_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] sample_value;
    logic                  first_of_run;
    logic                  last_of_run;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_byte;
    logic                  end_of_item;
    logic                  end_of_run;
    logic                  too_long;

    byte_stream_scoreboard sb = new();

    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_left = 0;
    int                    cycle_count = 0;
    logic [VALUE_BITS-1:0] last_sample = '0;

    delta_escape_width_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .first_of_run (first_of_run),
        .last_of_run  (last_of_run),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .end_of_item  (end_of_item),
        .end_of_run   (end_of_run),
        .too_long     (too_long)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // receiver: random stall plus one long hold-off
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_byte(out_byte, end_of_item, end_of_run, too_long);
        end
    end

    task automatic send_item(input logic [VALUE_BITS-1:0] value, input logic first,
                             input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= value;
        first_of_run <= first;
        last_of_run <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.encode_sample(value, first, last);
        last_sample = value;
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    function automatic logic [DIFF_BITS-1:0] pick_delta();
        logic signed [DIFF_BITS-1:0] d;
        longint                      bounds[12];
        longint                      m;
        int                          s;
        bounds = '{127, -127, -128, 128, 32767, -32767, -32768, 32768,
                   2147483647, -2147483647, -64'sd2147483648, 64'sd2147483648};
        case ($urandom_range(9))
            0, 1, 2:
            begin
                s = int'($urandom_range(254)) - 127;
                d = s;
            end
            3:
            begin
                s = $urandom_range(32767, 128);
                d = $urandom_range(1) ? -s : s;
            end
            4:
            begin
                m = longint'($urandom_range(32'h7FFF_FFFF, 32768)) + $urandom_range(1);
                d = $urandom_range(1) ? -m : m;
            end
            5: d = bounds[$urandom_range(11)];
            6: d = {$urandom, $urandom};
            7: d = '0;
            default:
            begin
                s = int'($urandom_range(2000)) - 1000;
                d = s;
            end
        endcase
        return d;
    endfunction

    task automatic send_random_runs(input int count);
        int                          sent;
        int                          len;
        logic                        start;
        logic                        close;
        logic signed [DIFF_BITS-1:0] base;
        sent = 0;
        while (sent < count)
        begin
            start = ($urandom_range(9) != 0);
            close = ($urandom_range(9) != 0);
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
            begin
                if (start && k == 0)
                    base = '0;
                else
                    base = $signed(last_sample);
                send_item(VALUE_BITS'(base + pick_delta()), start && k == 0,
                          close && k == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        sample_value <= '0;
        first_of_run <= 1'b0;
        last_of_run <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // run continues from reset state, then each width escalation
        send_item(63'sd5, 1'b0, 1'b0);
        send_item(63'sd132, 1'b0, 1'b0);
        send_item(63'sd5, 1'b0, 1'b0);
        send_item(-63'sd123, 1'b0, 1'b1);
        send_item(63'sd7, 1'b0, 1'b0);
        send_item(-63'sd128, 1'b1, 1'b0);
        send_item(63'sd32640, 1'b0, 1'b0);
        send_item(-63'sd2147451008, 1'b0, 1'b0);
        send_item(SAMPLE_MAX, 1'b0, 1'b0);
        send_item(SAMPLE_MIN, 1'b0, 1'b1);
        send_item(SAMPLE_MIN, 1'b1, 1'b1);
        send_item(SAMPLE_MAX, 1'b1, 1'b1);
        send_item(63'sd0, 1'b1, 1'b0);
        send_item(63'sd32767, 1'b0, 1'b0);
        send_item(-63'sd1, 1'b0, 1'b1);
        send_item(63'sd2147483647, 1'b1, 1'b0);
        send_item(-63'sd1, 1'b0, 1'b1);
        drain_outputs();

        write_limit('0);
        send_item(63'sd1, 1'b1, 1'b0);
        send_item(63'sd2, 1'b0, 1'b1);
        drain_outputs();
        write_limit(16'd20);
        send_item(63'sd10, 1'b1, 1'b0);
        send_item(-63'sd40000, 1'b0, 1'b0);
        drain_outputs();
        // limit raised in the middle of a run, then a new run starts
        write_limit(LIMIT_RESET);
        send_item(63'sd5, 1'b0, 1'b0);
        send_item(63'sd5, 1'b1, 1'b0);
        drain_outputs();
        // limit lowered in the middle of a run
        write_limit(16'd3);
        send_item(63'sd6, 1'b0, 1'b0);
        send_item(63'sd300, 1'b0, 1'b1);
        drain_outputs();

        write_limit(16'($urandom_range(400, 40)));
        hold_left = 400;
        send_random_runs(125);
        drain_outputs();

        idle_pct = 75;
        write_limit(LIMIT_RESET);
        send_random_runs(125);
        drain_outputs();

        idle_pct = 0;
        stall_pct = 75;
        write_limit(16'($urandom_range(200)));
        send_random_runs(125);
        drain_outputs();

        idle_pct = 14;
        stall_pct = 14;
        write_limit(16'($urandom_range(65535)));
        send_random_runs(125);
        drain_outputs();

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
